>>> src/vad_pkg.sv
`default_nettype none
package vad_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STAGES  = 16;

    localparam int ANG_FRAC    = 16;
    localparam int OUT_FRAC    = 7;
    localparam int ANGLE_BITS  = 16;
    localparam int ROUND_SHIFT = ANG_FRAC - OUT_FRAC;

    // Guard bits for the scaled components plus headroom for the CORDIC gain.
    localparam int DP_W  = COMPONENT_BITS + CORDIC_STAGES + 3;
    localparam int ACC_W = 27;
    localparam int Q_W   = ACC_W - ROUND_SHIFT;

    localparam int STAGE_IDX_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int TABLE_IDX_W = 5;

    localparam logic signed [ACC_W-1:0] DEG180_Q  = ACC_W'(180 * (1 << ANG_FRAC));
    localparam logic signed [ACC_W-1:0] DEG360_Q  = ACC_W'(360 * (1 << ANG_FRAC));
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (ROUND_SHIFT - 1));
    localparam logic [Q_W-1:0]          FULL_TURN = Q_W'(360 * (1 << OUT_FRAC));

    typedef struct packed {
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } vad_data_t;

    // atan(2^-i) in degrees with 16 fraction bits.
    function automatic logic signed [ACC_W-1:0] atan_step(input logic [TABLE_IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = ACC_W'(2949120);
            5'd1:    v = ACC_W'(1740967);
            5'd2:    v = ACC_W'(919879);
            5'd3:    v = ACC_W'(466945);
            5'd4:    v = ACC_W'(234379);
            5'd5:    v = ACC_W'(117304);
            5'd6:    v = ACC_W'(58666);
            5'd7:    v = ACC_W'(29335);
            5'd8:    v = ACC_W'(14668);
            5'd9:    v = ACC_W'(7334);
            5'd10:   v = ACC_W'(3667);
            5'd11:   v = ACC_W'(1833);
            5'd12:   v = ACC_W'(917);
            5'd13:   v = ACC_W'(458);
            5'd14:   v = ACC_W'(229);
            5'd15:   v = ACC_W'(115);
            5'd16:   v = ACC_W'(57);
            5'd17:   v = ACC_W'(29);
            5'd18:   v = ACC_W'(14);
            5'd19:   v = ACC_W'(7);
            5'd20:   v = ACC_W'(4);
            5'd21:   v = ACC_W'(2);
            5'd22:   v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/vad_cordic_stage.sv
`default_nettype none
module vad_cordic_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [vad_pkg::STAGE_IDX_W-1:0] stage_idx,
    input  wire logic                            up_valid,
    output logic                                 up_ready,
    input  wire vad_pkg::vad_data_t              up_data,
    output logic                                 dn_valid,
    input  wire logic                            dn_ready,
    output vad_pkg::vad_data_t                   dn_data
);
    import vad_pkg::*;

    logic                    valid_reg;
    vad_data_t               data_reg;
    vad_data_t               data_next;
    logic signed [DP_W-1:0]  xs;
    logic signed [DP_W-1:0]  ys;
    logic signed [ACC_W-1:0] step;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        xs   = up_data.x >>> stage_idx;
        ys   = up_data.y >>> stage_idx;
        step = atan_step(TABLE_IDX_W'(stage_idx));
        data_next.zero = up_data.zero;
        // Rotate towards the x axis: the sign of y picks the direction.
        if (!up_data.y[DP_W-1]) begin
            data_next.x   = up_data.x + ys;
            data_next.y   = up_data.y - xs;
            data_next.acc = up_data.acc + step;
        end else begin
            data_next.x   = up_data.x - ys;
            data_next.y   = up_data.y + xs;
            data_next.acc = up_data.acc - step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

>>> src/vector_angle_degrees.sv
`default_nettype none
// Pipeline: one input register, one register per CORDIC micro-rotation, and one register for
// the quadrant wrap and rounding.
// Throughput: one vector per cycle while m_ready is high; each stage has its own valid bit and
// ready, so bubbles close up and a stalled output does not stop the earlier stages from filling.
// Reset (aresetn low, synchronous) clears every valid bit; the datapath registers are not reset.
module vector_angle_degrees (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_valid,
    output logic                                            s_ready,
    input  wire logic signed [vad_pkg::COMPONENT_BITS-1:0]  s_vec_x,
    input  wire logic signed [vad_pkg::COMPONENT_BITS-1:0]  s_vec_y,
    output logic                                            m_valid,
    input  wire logic                                       m_ready,
    output logic [vad_pkg::ANGLE_BITS-1:0]                  m_angle_deg,
    output logic                                            m_zero_vector
);
    import vad_pkg::*;

    logic                    valid_chain [0:CORDIC_STAGES];
    logic                    ready_chain [0:CORDIC_STAGES];
    vad_data_t               data_chain  [0:CORDIC_STAGES];

    logic                    in_valid_reg;
    vad_data_t               in_data_reg;
    vad_data_t               in_data_next;
    logic signed [COMPONENT_BITS:0] x_ext;
    logic signed [COMPONENT_BITS:0] y_ext;

    logic                    out_valid_reg;
    logic [ANGLE_BITS-1:0]   angle_reg;
    logic                    zero_reg;
    logic [ANGLE_BITS-1:0]   angle_next;
    logic signed [ACC_W-1:0] acc_wrap;
    logic signed [ACC_W-1:0] acc_round;
    logic [Q_W-1:0]          q7;

    // Input register: zero detect and turn a vector with negative x through 180 degrees.
    always_comb begin
        x_ext = (COMPONENT_BITS + 1)'(s_vec_x);
        y_ext = (COMPONENT_BITS + 1)'(s_vec_y);
        in_data_next.zero = (s_vec_x == '0) && (s_vec_y == '0);
        if (s_vec_x[COMPONENT_BITS-1]) begin
            in_data_next.x   = DP_W'(-x_ext) <<< CORDIC_STAGES;
            in_data_next.y   = DP_W'(-y_ext) <<< CORDIC_STAGES;
            in_data_next.acc = DEG180_Q;
        end else begin
            in_data_next.x   = DP_W'(x_ext) <<< CORDIC_STAGES;
            in_data_next.y   = DP_W'(y_ext) <<< CORDIC_STAGES;
            in_data_next.acc = '0;
        end
    end

    assign s_ready = !in_valid_reg || ready_chain[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= in_data_next;
        end
    end

    assign valid_chain[0] = in_valid_reg;
    assign data_chain[0]  = in_data_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        vad_cordic_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (STAGE_IDX_W'(i)),
            .up_valid  (valid_chain[i]),
            .up_ready  (ready_chain[i]),
            .up_data   (data_chain[i]),
            .dn_valid  (valid_chain[i+1]),
            .dn_ready  (ready_chain[i+1]),
            .dn_data   (data_chain[i+1])
        );
    end

    // Output register: wrap negatives by a full turn, round half up to 7 fraction bits, fold 360 to 0.
    always_comb begin
        acc_wrap  = data_chain[CORDIC_STAGES].acc[ACC_W-1]
                  ? data_chain[CORDIC_STAGES].acc + DEG360_Q
                  : data_chain[CORDIC_STAGES].acc;
        acc_round = acc_wrap + ROUND_ADD;
        q7        = acc_round[ACC_W-1:ROUND_SHIFT];
        if (q7 >= FULL_TURN) begin
            q7 = q7 - FULL_TURN;
        end
        angle_next = data_chain[CORDIC_STAGES].zero ? '0 : q7[ANGLE_BITS-1:0];
    end

    assign ready_chain[CORDIC_STAGES] = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ready_chain[CORDIC_STAGES]) begin
            out_valid_reg <= valid_chain[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_chain[CORDIC_STAGES] && ready_chain[CORDIC_STAGES]) begin
            angle_reg <= angle_next;
            zero_reg  <= data_chain[CORDIC_STAGES].zero;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_angle_deg   = angle_reg;
    assign m_zero_vector = zero_reg;

    a_zero_forces_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_vector |-> m_angle_deg == '0)
        else $error("zero vector request carries a non-zero angle");

    a_angle_below_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle_deg < ANGLE_BITS'(FULL_TURN))
        else $error("angle reached a full turn");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("valid bits survived reset");

    a_input_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && ready_chain[0] |-> s_ready)
        else $error("input register stalled while the first stage was free");

endmodule
`default_nettype wire
